// ----- rtl/clt_pkg.sv -----
// ----------------------------------------------------------------------------
// clt_pkg
// types, codes and character classes shared by the command line tokenizer
// ----------------------------------------------------------------------------
`default_nettype none

package clt_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_STRING = 3'd1;
    localparam logic [2:0] MODE_NUMBER = 3'd2;
    localparam logic [2:0] MODE_JUNK   = 3'd3;
    localparam logic [2:0] MODE_IDENT  = 3'd4;

    localparam logic [2:0] KIND_END     = 3'd0;
    localparam logic [2:0] KIND_ERROR   = 3'd1;
    localparam logic [2:0] KIND_PUNCT   = 3'd2;
    localparam logic [2:0] KIND_SPACE   = 3'd3;
    localparam logic [2:0] KIND_NEWLINE = 3'd4;
    localparam logic [2:0] KIND_STRING  = 3'd5;
    localparam logic [2:0] KIND_INT     = 3'd6;
    localparam logic [2:0] KIND_IDENT   = 3'd7;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VTAB   = 8'h0b;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef logic [OFFSET_BITS-1:0] offset_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] accum;
        logic [15:0] length;
        offset_t     start;
        offset_t     pos;
        logic        ended;
    } clt_state_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
        logic [15:0] start;
        logic        last;
    } clt_res_t;

    function automatic logic [15:0] to_start(input offset_t off);
        logic [31:0] ext;
        ext = 32'(off);
        return ext[15:0];
    endfunction

    function automatic clt_res_t mk_res(input logic [2:0] kind, input logic [31:0] value,
                                        input offset_t off);
        clt_res_t r;
        r.kind  = kind;
        r.value = value;
        r.start = to_start(off);
        r.last  = 1'b0;
        return r;
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c == CH_COMMA) || (c == CH_SEMI) || (c == CH_COLON) || (c == CH_PLUS);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VTAB);
    endfunction

    function automatic logic is_newline(input logic [7:0] c);
        return (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
    endfunction

    function automatic logic is_term(input logic [7:0] c);
        return is_punct(c) || is_space(c) || is_newline(c) || (c == CH_NUL);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/command_line_tokenizer_unit.sv -----
// ----------------------------------------------------------------------------
// command_line_tokenizer_unit
// byte stream in, tokens out (end, error, punct, space, newline, string,
// integer, identifier)
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with data_byte and final_byte, one byte
//   per transaction; final_byte closes the buffer and restarts offsets at 0
//   output channel: out_valid / out_stall with token_kind, token_value,
//   token_start and run_last; run_last marks the last token of a byte
//   each accepted byte is scanned in the same cycle and its zero to three
//   tokens are written into a four-entry result queue; they reach the
//   output from that registered queue, behind any tokens still held
//   throughput: one byte per cycle while each byte yields at most one
//   token and the receiver does not stall; a byte yielding several tokens
//   holds the single output port, which drains the queue one at a time
//   in_stall rises whenever the queue holds more than one token, so a
//   receiver stall backs up into the input; held tokens stay in order and
//   are never dropped
//   reset clears the scan state, byte offset and queue; no tokens are pending
// ----------------------------------------------------------------------------
`default_nettype none

module command_line_tokenizer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        final_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       token_kind,
    output logic [31:0]      token_value,
    output logic [15:0]      token_start,
    output logic             run_last
);
    import clt_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    clt_state_t state_reg;
    clt_state_t state_next;
    clt_res_t   res [MAX_RESULTS];
    logic [1:0] res_count;

    clt_res_t              queue_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;
    logic                  accept;
    logic                  pop;
    logic [CNT_BITS-1:0]   push_count;

    clt_scan u_scan (
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .cur        (state_reg),
        .nxt        (state_next),
        .res        (res),
        .res_count  (res_count)
    );

    assign in_stall   = count_reg > CNT_BITS'(QUEUE_DEPTH - MAX_RESULTS);
    assign accept     = in_valid && !in_stall;
    assign out_valid  = count_reg != '0;
    assign pop        = out_valid && !out_stall;
    assign push_count = accept ? CNT_BITS'(res_count) : '0;
    assign count_next = count_reg + push_count - CNT_BITS'(pop);

    assign token_kind  = queue_reg[rd_ptr_reg].kind;
    assign token_value = queue_reg[rd_ptr_reg].value;
    assign token_start = queue_reg[rd_ptr_reg].start;
    assign run_last    = queue_reg[rd_ptr_reg].last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode  <= MODE_IDLE;
            state_reg.accum <= 32'd0;
            state_reg.length <= 16'd0;
            state_reg.start <= '0;
            state_reg.pos   <= '0;
            state_reg.ended <= 1'b0;
            rd_ptr_reg      <= '0;
            wr_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                state_reg  <= state_next;
                wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(res_count);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (accept && (2'(i) < res_count))
            begin
                queue_reg[wr_ptr_reg + PTR_BITS'(i)] <= res[i];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/clt_scan.sv -----
// ----------------------------------------------------------------------------
// clt_scan
// one byte of scanning: next tokenizer state and up to three tokens
// ----------------------------------------------------------------------------
`default_nettype none

module clt_scan (
    input  wire logic [7:0]          data_byte,
    input  wire logic                final_byte,
    input  wire clt_pkg::clt_state_t cur,
    output clt_pkg::clt_state_t      nxt,
    output clt_pkg::clt_res_t        res [clt_pkg::MAX_RESULTS],
    output logic [1:0]               res_count
);
    import clt_pkg::*;

    logic [7:0]  c;
    logic [15:0] grown;
    offset_t     pos_inc;

    assign c       = data_byte;
    assign grown   = (cur.length != 16'hffff) ? cur.length + 16'd1 : cur.length;
    assign pos_inc = cur.pos + offset_t'(1);

    always_comb
    begin
        logic [1:0] n;
        logic       bnd;
        n   = 2'd0;
        bnd = 1'b0;
        nxt = cur;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res[i] = mk_res(KIND_END, 32'd0, '0);
        end

        if (!cur.ended)
        begin
            unique case (cur.mode)
                MODE_STRING:
                begin
                    if (c == CH_QUOTE)
                    begin
                        res[n] = mk_res(KIND_STRING, 32'(cur.length), cur.start);
                        n = n + 2'd1;
                        nxt.mode = MODE_IDLE;
                    end
                    else if (c == CH_NUL || c[7] || is_newline(c))
                    begin
                        res[n] = mk_res(KIND_ERROR, 32'(cur.length), cur.start);
                        n = n + 2'd1;
                        nxt.mode = MODE_IDLE;
                        bnd = 1'b1;
                    end
                    else
                    begin
                        nxt.length = grown;
                    end
                end
                MODE_NUMBER:
                begin
                    if (is_digit(c))
                    begin
                        nxt.accum  = (cur.accum << 3) + (cur.accum << 1) + 32'(c[3:0]);
                        nxt.length = grown;
                    end
                    else if (is_term(c))
                    begin
                        res[n] = mk_res(KIND_INT, cur.accum, cur.start);
                        n = n + 2'd1;
                        nxt.mode = MODE_IDLE;
                        bnd = 1'b1;
                    end
                    else
                    begin
                        nxt.mode   = MODE_JUNK;
                        nxt.length = grown;
                    end
                end
                MODE_JUNK:
                begin
                    if (is_term(c))
                    begin
                        res[n] = mk_res(KIND_ERROR, 32'(cur.length), cur.start);
                        n = n + 2'd1;
                        nxt.mode = MODE_IDLE;
                        bnd = 1'b1;
                    end
                    else
                    begin
                        nxt.length = grown;
                    end
                end
                MODE_IDENT:
                begin
                    if (is_term(c) && c != CH_COLON)
                    begin
                        res[n] = mk_res(KIND_IDENT, 32'(cur.length), cur.start);
                        n = n + 2'd1;
                        nxt.mode = MODE_IDLE;
                        bnd = 1'b1;
                    end
                    else
                    begin
                        nxt.length = grown;
                    end
                end
                default:
                begin
                    nxt.mode = MODE_IDLE;
                    bnd = 1'b1;
                end
            endcase
        end

        // token boundary: the byte starts a new token
        if (bnd)
        begin
            if (c == CH_NUL || c[7])
            begin
                nxt.ended = 1'b1;
                res[n] = mk_res(KIND_END, 32'd0, cur.pos);
                n = n + 2'd1;
            end
            else if (is_punct(c))
            begin
                res[n] = mk_res(KIND_PUNCT, 32'(c), cur.pos);
                n = n + 2'd1;
            end
            else if (is_space(c))
            begin
                res[n] = mk_res(KIND_SPACE, 32'(c), cur.pos);
                n = n + 2'd1;
            end
            else if (is_newline(c))
            begin
                res[n] = mk_res(KIND_NEWLINE, 32'(c), cur.pos);
                n = n + 2'd1;
            end
            else if (c == CH_QUOTE)
            begin
                nxt.mode   = MODE_STRING;
                nxt.start  = pos_inc;
                nxt.length = 16'd0;
            end
            else if (is_digit(c))
            begin
                nxt.mode   = MODE_NUMBER;
                nxt.accum  = 32'(c[3:0]);
                nxt.start  = cur.pos;
                nxt.length = 16'd1;
            end
            else if (is_alpha(c))
            begin
                nxt.mode   = MODE_IDENT;
                nxt.start  = cur.pos;
                nxt.length = 16'd1;
            end
            else
            begin
                res[n] = mk_res(KIND_ERROR, 32'd1, cur.pos);
                n = n + 2'd1;
            end
        end

        // buffer close
        if (final_byte)
        begin
            if (!nxt.ended)
            begin
                case (nxt.mode)
                    MODE_STRING, MODE_JUNK:
                    begin
                        res[n] = mk_res(KIND_ERROR, 32'(nxt.length), nxt.start);
                        n = n + 2'd1;
                    end
                    MODE_NUMBER:
                    begin
                        res[n] = mk_res(KIND_INT, nxt.accum, nxt.start);
                        n = n + 2'd1;
                    end
                    MODE_IDENT:
                    begin
                        res[n] = mk_res(KIND_IDENT, 32'(nxt.length), nxt.start);
                        n = n + 2'd1;
                    end
                    default:
                    begin
                    end
                endcase
                res[n] = mk_res(KIND_END, 32'd0, pos_inc);
                n = n + 2'd1;
            end
            nxt.mode   = MODE_IDLE;
            nxt.accum  = 32'd0;
            nxt.length = 16'd0;
            nxt.start  = '0;
            nxt.pos    = '0;
            nxt.ended  = 1'b0;
        end
        else
        begin
            nxt.pos = pos_inc;
        end

        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res[i].last = (n == 2'(i + 1));
        end
        res_count = n;
    end

endmodule

`default_nettype wire
